/* hdl/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, request codes, character codes and defaults for the
// character-cell text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Field widths of the request and response transactions.
  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int COLOR_W  = 8;
  localparam int CELL_W   = 16;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MOVE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

  // Character codes with special meaning.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // Attribute after reset: light gray on black.
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

endpackage

/* hdl/tcw_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console stream interfaces
// Valid/ready channels for console requests and for their responses.
// ----------------------------------------------------------------------------
interface tcw_req_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::REQ_W-1:0]     req_type;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::ROW_W-1:0]     target_row;
  logic [tcw_pkg::COL_W-1:0]     target_col;
  logic [tcw_pkg::INDEX_W-1:0]   read_index;

  modport source (
    output valid, req_type, char_code, target_row, target_col, read_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, target_row, target_col, read_index,
    output ready
  );
endinterface

interface tcw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CURSOR_W-1:0]  cursor_pos;
  logic [tcw_pkg::CELL_W-1:0]    cell_data;

  modport source (
    output valid, cursor_pos, cell_data,
    input  ready
  );
  modport sink (
    input  valid, cursor_pos, cell_data,
    output ready
  );
endinterface

/* hdl/text_console_writer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer unit
// Character-cell console with a ROWS x COLUMNS screen store and a cursor,
// driven by a small sequencer around one cell memory and one address counter.
//
//   channel  direction  handshake     contents
//   req      in         valid/ready   req_type, char_code, target_row,
//                                     target_col, read_index
//   rsp      out        valid/ready   cursor_pos, cell_data
//   cfg      in         cfg_we        cfg_wdata (text color attribute)
//
// Every request passes through S_EXEC and S_DONE; a cell read also passes
// through S_RD_WAIT unless the index lies off the screen. A scroll walks the
// memory port, reading each cell below the top row and writing it one row
// up, then blanks the bottom row; a clear fills every cell through the same
// write port.
// After reset a clearing pass fills the screen with blanks; req.ready stays
// low until it ends. Config writes are taken in every sequencer state.
// A new request is taken once the previous one has finished; a response held
// by a stalled sink does not block it until the next response is ready.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                         clk,
  input  logic                         rst,
  tcw_req_if.sink                      req,
  tcw_rsp_if.source                    rsp,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata
);

  localparam int CELL_COUNT  = ROWS * COLUMNS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int CMP_W       = ADDR_W + tcw_pkg::CURSOR_W;
  localparam int SCROLL_LAST = (ROWS - 1) * COLUMNS - 1;

  // Sequencer states.
  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_EXEC    = 4'd2;
  localparam logic [3:0] S_RD_WAIT = 4'd3;
  localparam logic [3:0] S_SCR_RD  = 4'd4;
  localparam logic [3:0] S_SCR_WR  = 4'd5;
  localparam logic [3:0] S_FILL    = 4'd6;
  localparam logic [3:0] S_DONE    = 4'd7;

  logic [3:0]                         state;
  logic [ADDR_W-1:0]                  idx;
  logic [tcw_pkg::ROW_W-1:0]          cur_row;
  logic [tcw_pkg::COL_W-1:0]          cur_col;
  logic [ADDR_W-1:0]                  row_base;
  logic [tcw_pkg::COLOR_W-1:0]        text_color;
  logic [tcw_pkg::CELL_W-1:0]         res_data;
  logic                               out_valid;
  logic [tcw_pkg::CURSOR_W-1:0]       out_cursor;
  logic [tcw_pkg::CELL_W-1:0]         out_data;

  // Registered request fields.
  logic [tcw_pkg::REQ_W-1:0]          r_type;
  logic [tcw_pkg::CHAR_W-1:0]         r_char;
  logic [tcw_pkg::ROW_W-1:0]          r_trow;
  logic [tcw_pkg::COL_W-1:0]          r_tcol;
  logic [tcw_pkg::INDEX_W-1:0]        r_ridx;

  // Cell memory.
  logic [tcw_pkg::CELL_W-1:0]         cells [CELL_COUNT];
  logic                               mem_we;
  logic [ADDR_W-1:0]                  mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]         mem_wdata;
  logic                               mem_re;
  logic [ADDR_W-1:0]                  mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]         mem_rdata;

  // Derived values.
  logic [ADDR_W-1:0]                  lin;
  logic [CMP_W-1:0]                   lin_ext;
  logic [CMP_W-1:0]                   ridx_ext;
  logic                               ridx_ok;
  logic [tcw_pkg::CELL_W-1:0]         blank;
  logic                               is_special;
  logic                               row_last;
  logic                               col_last;
  logic [tcw_pkg::ROW_W-1:0]          sat_row;
  logic [tcw_pkg::COL_W-1:0]          sat_col;

  assign lin        = row_base + ADDR_W'(cur_col);
  assign lin_ext    = CMP_W'(lin);
  assign ridx_ext   = CMP_W'(r_ridx);
  assign ridx_ok    = ridx_ext < CMP_W'(CELL_COUNT);
  assign blank      = {text_color, tcw_pkg::CH_SPACE};
  assign is_special = (r_char == tcw_pkg::CH_NEWLINE) || (r_char == tcw_pkg::CH_RETURN)
                   || (r_char == tcw_pkg::CH_BACKSPACE);
  assign row_last   = cur_row == tcw_pkg::ROW_W'(ROWS - 1);
  assign col_last   = cur_col == tcw_pkg::COL_W'(COLUMNS - 1);
  assign sat_row    = ({1'b0, r_trow} < (tcw_pkg::ROW_W + 1)'(ROWS))
                    ? r_trow : tcw_pkg::ROW_W'(ROWS - 1);
  assign sat_col    = ({1'b0, r_tcol} < (tcw_pkg::COL_W + 1)'(COLUMNS))
                    ? r_tcol : tcw_pkg::COL_W'(COLUMNS - 1);

  // Handshake outputs.
  assign req.ready      = state == S_IDLE;
  assign rsp.valid      = out_valid;
  assign rsp.cursor_pos = out_cursor;
  assign rsp.cell_data  = out_data;

  // Memory port control for each sequencer step.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = idx + ADDR_W'(COLUMNS);
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_SCR_RD: begin
        mem_re = 1'b1;
      end
      S_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      S_EXEC: begin
        if (r_type == tcw_pkg::REQ_PUT) begin
          if (r_char == tcw_pkg::CH_BACKSPACE) begin
            mem_we    = cur_col != '0;
            mem_waddr = lin - ADDR_W'(1);
          end else if (!is_special) begin
            mem_we    = 1'b1;
            mem_waddr = lin;
            mem_wdata = {text_color, r_char};
          end
        end else if (r_type == tcw_pkg::REQ_READ) begin
          mem_re    = ridx_ok;
          mem_raddr = ridx_ext[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Cell memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= cells[mem_raddr];
    end
  end

  // Color register.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::RESET_COLOR;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  // Sequencer, cursor and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      row_base  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (idx == ADDR_W'(CELL_COUNT - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            r_type <= req.req_type;
            r_char <= req.char_code;
            r_trow <= req.target_row;
            r_tcol <= req.target_col;
            r_ridx <= req.read_index;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_data <= '0;
          state    <= S_DONE;
          unique case (r_type)
            tcw_pkg::REQ_PUT: begin
              if (r_char == tcw_pkg::CH_RETURN) begin
                cur_col <= '0;
              end else if (r_char == tcw_pkg::CH_BACKSPACE) begin
                if (cur_col != '0) begin
                  cur_col <= cur_col - tcw_pkg::COL_W'(1);
                end
              end else if (r_char == tcw_pkg::CH_NEWLINE || col_last) begin
                // Line feed, explicit or by wrap; the bottom row scrolls.
                cur_col <= '0;
                if (row_last) begin
                  idx   <= '0;
                  state <= S_SCR_RD;
                end else begin
                  cur_row  <= cur_row + tcw_pkg::ROW_W'(1);
                  row_base <= row_base + ADDR_W'(COLUMNS);
                end
              end else begin
                cur_col <= cur_col + tcw_pkg::COL_W'(1);
              end
            end
            tcw_pkg::REQ_MOVE: begin
              cur_row  <= sat_row;
              cur_col  <= sat_col;
              row_base <= ADDR_W'(sat_row * COLUMNS);
            end
            tcw_pkg::REQ_CLEAR: begin
              cur_row  <= '0;
              cur_col  <= '0;
              row_base <= '0;
              idx      <= '0;
              state    <= S_FILL;
            end
            tcw_pkg::REQ_READ: begin
              if (ridx_ok) begin
                state <= S_RD_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
        S_RD_WAIT: begin
          res_data <= mem_rdata;
          state    <= S_DONE;
        end
        S_SCR_RD: begin
          state <= S_SCR_WR;
        end
        S_SCR_WR: begin
          idx <= idx + ADDR_W'(1);
          if (idx == ADDR_W'(SCROLL_LAST)) begin
            state <= S_FILL;
          end else begin
            state <= S_SCR_RD;
          end
        end
        S_FILL: begin
          if (idx == ADDR_W'(CELL_COUNT - 1)) begin
            state <= S_DONE;
          end else begin
            idx <= idx + ADDR_W'(1);
          end
        end
        S_DONE: begin
          // Load the response once the output register is free.
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_cursor <= lin_ext[tcw_pkg::CURSOR_W-1:0];
            out_data   <= res_data;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/tcw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions on the console unit, attached to it by bind.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [tcw_pkg::CURSOR_W-1:0]  cursor_pos,
  input logic [tcw_pkg::CELL_W-1:0]    cell_data
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int CMP_W      = tcw_pkg::CURSOR_W + 2;

  // A stalled response holds its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_pos) && $stable(cell_data))
    else $error("response changed while stalled");

  // The clearing pass keeps requests out right after reset.
  a_init_busy: assert property (@(posedge clk)
    !rst && $past(rst) |-> !req_ready)
    else $error("request port ready during the clearing pass");

  // One request at a time: the port closes after each transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request port stayed open after a transaction");

  // A cursor reported in a response lies on the screen (checked up to 2047 cells).
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CMP_W'(cursor_pos) < CMP_W'(CELL_COUNT)) || (CELL_COUNT > 2047))
    else $error("cursor position beyond the screen");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .cursor_pos (rsp.cursor_pos),
  .cell_data  (rsp.cell_data)
);
